### rtl/sfs_pkg.sv
package sfs_pkg;

  // Sizes
  localparam int MAX_FRAMES = 16;
  localparam int TIME_BITS  = 16;
  localparam int FRAME_W    = $clog2(MAX_FRAMES);
  localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
  localparam int ELAPSED_W  = TIME_BITS + 1;
  localparam int STEP_W     = 16;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 4;

  // Item kinds
  localparam logic [1:0] KIND_TICK      = 2'd0;
  localparam logic [1:0] KIND_LOAD      = 2'd1;
  localparam logic [1:0] KIND_SET_FRAME = 2'd2;
  localparam logic [1:0] KIND_RUN       = 2'd3;

  // Register indexes (word address bits)
  localparam logic [1:0] REG_FRAME_COUNT = 2'd0;
  localparam logic [1:0] REG_LOOP        = 2'd1;
  localparam logic [1:0] REG_REWIND      = 2'd2;

  typedef struct packed {
    logic [1:0]           kind;
    logic [TIME_BITS-1:0] frame_time;
    logic [FRAME_W-1:0]   frame_index;
    logic [TIME_BITS-1:0] duration;
    logic                 run;
  } sfs_item_t;

  typedef struct packed {
    logic [FRAME_W-1:0] current_frame;
    logic               is_paused;
    logic               moving_forward;
    logic [STEP_W-1:0]  frames_stepped;
  } sfs_result_t;

  typedef struct packed {
    logic [CNT_W-1:0] frame_count;
    logic             loop_enable;
    logic             rewind_backward;
  } sfs_cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic start;  // take the word and apply it
    logic rd;     // read the current frame's duration
    logic sub;    // one expiry: subtract duration, count it
    logic adv;    // step the frame along with sub
    logic emit;   // load the result register
  } sfs_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic tick_go;   // word at the input is a tick that will run
    logic ge;        // elapsed time reaches the duration
    logic paused;
    logic out_free;  // result register can take a word
  } sfs_stat_t;

endpackage

### rtl/sfs_ctrl.sv
module sfs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  sfs_pkg::sfs_stat_t stat,
  output sfs_pkg::sfs_cmd_t  cmd
);
  import sfs_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_TEST = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  // Sequence one word: apply, then loop read/test over expiries, then emit
  always_comb begin
    cmd        = '0;
    state_next = state;
    item_stall = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          cmd.start  = 1'b1;
          state_next = stat.tick_go ? ST_READ : ST_DONE;
        end
      end
      ST_READ: begin
        cmd.rd     = 1'b1;
        state_next = ST_TEST;
      end
      ST_TEST: begin
        if (!stat.ge) begin
          state_next = ST_DONE;
        end else if (stat.paused) begin
          // frame holds, duration stays valid: keep subtracting
          cmd.sub = 1'b1;
        end else begin
          cmd.sub    = 1'b1;
          cmd.adv    = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_test_exit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TEST && !stat.ge) |=> (state == ST_DONE))
    else $error("loop did not finish when time ran short");

  a_done_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && !stat.out_free) |=> (state == ST_DONE))
    else $error("left done while result register was busy");

endmodule

### rtl/sfs_dp.sv
module sfs_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  sfs_pkg::sfs_cfg_t    cfg,
  input  sfs_pkg::sfs_item_t   item,
  input  sfs_pkg::sfs_cmd_t    cmd,
  output sfs_pkg::sfs_stat_t   stat,
  output logic                 result_valid,
  input  logic                 result_stall,
  output sfs_pkg::sfs_result_t result
);
  import sfs_pkg::*;

  logic [TIME_BITS-1:0] mem [MAX_FRAMES];
  logic [TIME_BITS-1:0] dur_raw;
  logic [TIME_BITS-1:0] dur;
  logic [FRAME_W-1:0]   frame_now;
  logic [ELAPSED_W-1:0] elapsed;
  logic                 forward;
  logic                 paused;
  logic [STEP_W-1:0]    steps;

  logic [CNT_W-1:0]     cnt;
  logic [CNT_W-1:0]     last;
  logic [FRAME_W-1:0]   last_f;
  logic [FRAME_W-1:0]   clamp_frame;
  logic [ELAPSED_W-1:0] elapsed_sum;
  logic [FRAME_W-1:0]   adv_frame;
  logic                 adv_fwd;
  logic                 adv_pause;

  // Effective frame count and last index
  assign cnt    = (cfg.frame_count > CNT_W'(MAX_FRAMES)) ? CNT_W'(MAX_FRAMES)
                                                         : cfg.frame_count;
  assign last   = cnt - CNT_W'(1);
  assign last_f = last[FRAME_W-1:0];

  assign clamp_frame = ({1'b0, frame_now} >= cnt) ? last_f : frame_now;
  assign elapsed_sum = elapsed + {1'b0, item.frame_time};

  // Zero duration counts as one
  assign dur = (dur_raw == '0) ? TIME_BITS'(1) : dur_raw;

  assign stat.tick_go  = (item.kind == KIND_TICK) && !paused && (cnt >= CNT_W'(2));
  assign stat.ge       = (elapsed >= {1'b0, dur});
  assign stat.paused   = paused;
  assign stat.out_free = !result_valid || !result_stall;

  // Next frame, direction and pause after one expiry
  always_comb begin
    adv_frame = frame_now;
    adv_fwd   = forward;
    adv_pause = paused;
    if (forward) begin
      if (frame_now == last_f) begin
        if (cfg.rewind_backward) begin
          adv_fwd   = 1'b0;
          adv_frame = frame_now - FRAME_W'(1);
        end else if (!cfg.loop_enable) begin
          adv_pause = 1'b1;
        end else begin
          adv_frame = '0;
        end
      end else begin
        adv_frame = frame_now + FRAME_W'(1);
      end
    end else begin
      if (frame_now == '0) begin
        if (!cfg.loop_enable) begin
          adv_pause = 1'b1;
        end else begin
          adv_fwd   = 1'b1;
          adv_frame = frame_now + FRAME_W'(1);
        end
      end else begin
        adv_frame = frame_now - FRAME_W'(1);
      end
    end
  end

  // Sequencer state and result handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_now    <= '0;
      elapsed      <= '0;
      forward      <= 1'b1;
      paused       <= 1'b1;
      steps        <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.start) begin
        steps <= '0;
        unique case (item.kind)
          KIND_TICK: begin
            if (stat.tick_go) begin
              frame_now <= clamp_frame;
              elapsed   <= elapsed_sum;
            end
          end
          KIND_LOAD: begin
          end
          KIND_SET_FRAME: begin
            if ({1'b0, item.frame_index} < cnt) begin
              frame_now <= item.frame_index;
            end
          end
          KIND_RUN: begin
            paused <= !item.run;
          end
        endcase
      end
      if (cmd.sub) begin
        elapsed <= elapsed - {1'b0, dur};
        if (steps != '1) begin
          steps <= steps + STEP_W'(1);
        end
        if (cmd.adv) begin
          frame_now <= adv_frame;
          forward   <= adv_fwd;
          paused    <= adv_pause;
        end
      end
      if (cmd.emit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Duration memory and registered read
  always_ff @(posedge clk) begin
    if (cmd.start && item.kind == KIND_LOAD) begin
      mem[item.frame_index] <= item.duration;
    end
    if (cmd.rd) begin
      dur_raw <= mem[frame_now];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.current_frame  <= frame_now;
      result.is_paused      <= paused;
      result.moving_forward <= forward;
      result.frames_stepped <= steps;
    end
  end

  a_pause_holds_frame: assert property (@(posedge clk) disable iff (rst)
    (cmd.sub && !cmd.adv) |=> $stable(frame_now))
    else $error("frame moved during a paused expiry");

  a_steps_quiet: assert property (@(posedge clk) disable iff (rst)
    (!cmd.start && !cmd.sub) |=> $stable(steps))
    else $error("step count changed outside a tick loop");

endmodule

### rtl/sprite_frame_sequencer_unit.sv
// Sprite frame sequencer.
// Input channel (item_valid / item_stall / item) takes one word per command:
// tick, load duration, set frame or set run/pause. Each word yields exactly
// one result word on result_valid / result_stall / result.
// Configuration registers sit on the APB port: frame_count at 0x0,
// loop_enable at 0x4, rewind_backward at 0x8. Write them only while idle.
// Order: a non-tick word, or a tick while paused or with fewer than two
// frames, goes from acceptance to the done state and then into the result
// register. A running tick first does one duration memory read and one
// compare/subtract for each expiry that steps the frame, and one compare/
// subtract for each expiry counted after the sequence pauses.
// One word is in work at a time; the next is taken once the result is
// loaded into the output register, so a stalled receiver blocks the block
// only when a second result is ready.
// Reset: frame 0, elapsed time 0, forward, paused, registers 0. Durations
// are undefined until loaded.
module sprite_frame_sequencer_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  sfs_pkg::sfs_item_t              item,
  output logic                            result_valid,
  input  logic                            result_stall,
  output sfs_pkg::sfs_result_t            result,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sfs_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [sfs_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [sfs_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import sfs_pkg::*;

  sfs_cfg_t  cfg;
  sfs_cmd_t  cmd;
  sfs_stat_t stat;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_FRAME_COUNT: cfg.frame_count     <= pwdata[CNT_W-1:0];
        REG_LOOP:        cfg.loop_enable     <= pwdata[0];
        REG_REWIND:      cfg.rewind_backward <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Configuration reads
  always_comb begin
    unique case (reg_sel)
      REG_FRAME_COUNT: prdata = APB_DATA_W'(cfg.frame_count);
      REG_LOOP:        prdata = APB_DATA_W'(cfg.loop_enable);
      REG_REWIND:      prdata = APB_DATA_W'(cfg.rewind_backward);
      default:         prdata = '0;
    endcase
  end

  sfs_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  sfs_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .item         (item),
    .cmd          (cmd),
    .stat         (stat),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb;
  import sfs_pkg::*;

  localparam int HOLD_CYCLES     = 300;
  localparam int PRESSURE_PHASE  = 7;
  localparam int WORDS_PER_PHASE = 55;
  localparam int PHASES          = 10;

  // One line of the directed plan: either a register setting or a word
  typedef struct {
    bit          is_mode;
    int          cnt;
    bit          lp;
    bit          rw;
    sfs_item_t   w;
    bit          typed;
    sfs_result_t want;
  } plan_row_t;

  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  item_valid   = 1'b0;
  logic                  item_stall;
  sfs_item_t             item         = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  sfs_result_t           result;
  logic                  psel         = 1'b0;
  logic                  penable      = 1'b0;
  logic                  pwrite       = 1'b0;
  logic [APB_ADDR_W-1:0] paddr        = '0;
  logic [APB_DATA_W-1:0] pwdata       = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // Animation state as the testbench tracks it
  logic [TIME_BITS-1:0] hold_time [MAX_FRAMES];
  int unsigned          frame_at   = 0;
  int unsigned          elapsed    = 0;
  bit                   moving_up  = 1'b1;
  bit                   halted     = 1'b1;
  int unsigned          cfg_count  = 0;
  bit                   cfg_loop   = 1'b0;
  bit                   cfg_rewind = 1'b0;

  sfs_result_t expected_frames [$];
  plan_row_t   dir_rows [$];

  int   tx_idle_pct = 26;
  int   rx_idle_pct = 71;
  logic hold_req    = 1'b0;
  logic hold_done   = 1'b0;
  int   hold_left   = 0;

  int     mismatch_count = 0;
  int     results_seen   = 0;
  int     words_sent     = 0;
  int     ticks_sent     = 0;
  int     modes_used     = 0;
  longint steps_total    = 0;

  int plan_count  [PHASES] = '{16, 16, 5, 3, 2, 1, 0, 7, 16, 2};
  bit plan_loop   [PHASES] = '{1, 1, 0, 0, 1, 1, 0, 1, 0, 0};
  bit plan_rewind [PHASES] = '{0, 1, 0, 1, 1, 0, 0, 1, 1, 0};

  logic [1:0] reg_ids [3] = '{REG_FRAME_COUNT, REG_LOOP, REG_REWIND};

  sprite_frame_sequencer_unit i_dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #100_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic void note_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch: %s", msg);
  endfunction

  function automatic sfs_item_t mk_word(logic [1:0] kind, int ft, int idx, int dur, bit run);
    sfs_item_t w;
    w.kind        = kind;
    w.frame_time  = TIME_BITS'(ft);
    w.frame_index = FRAME_W'(idx);
    w.duration    = TIME_BITS'(dur);
    w.run         = run;
    return w;
  endfunction

  function automatic plan_row_t word_row(sfs_item_t w, bit typed, sfs_result_t want);
    plan_row_t r;
    r.is_mode = 1'b0;
    r.cnt     = 0;
    r.lp      = 1'b0;
    r.rw      = 1'b0;
    r.w       = w;
    r.typed   = typed;
    r.want    = want;
    return r;
  endfunction

  function automatic plan_row_t mode_row(int cnt, bit lp, bit rw);
    plan_row_t r;
    r         = word_row('0, 1'b0, '0);
    r.is_mode = 1'b1;
    r.cnt     = cnt;
    r.lp      = lp;
    r.rw      = rw;
    return r;
  endfunction

  // A stored zero counts as one time unit
  function automatic int unsigned duration_of(int unsigned f);
    return (hold_time[f] == 0) ? 1 : hold_time[f];
  endfunction

  // Move one frame along the current direction, honoring loop and rewind
  function automatic void advance_frame(int unsigned n);
    if (moving_up) begin
      if (frame_at == n - 1) begin
        if (cfg_rewind) begin
          moving_up = 1'b0;
          frame_at--;
        end else if (!cfg_loop) begin
          halted = 1'b1;
        end else begin
          frame_at = 0;
        end
      end else begin
        frame_at++;
      end
    end else begin
      if (frame_at == 0) begin
        if (!cfg_loop) begin
          halted = 1'b1;
        end else begin
          moving_up = 1'b1;
          frame_at++;
        end
      end else begin
        frame_at--;
      end
    end
  endfunction

  // Apply one accepted word to the tracked state and form its result
  function automatic sfs_result_t sequence_step(sfs_item_t w);
    sfs_result_t r;
    int unsigned n_frames;
    int unsigned span;
    int unsigned steps;
    int unsigned q;
    n_frames = (cfg_count > MAX_FRAMES) ? MAX_FRAMES : cfg_count;
    steps    = 0;
    case (w.kind)
      KIND_TICK: begin
        if (!halted && n_frames >= 2) begin
          if (frame_at >= n_frames) frame_at = n_frames - 1;
          elapsed = elapsed + w.frame_time;
          span    = duration_of(frame_at);
          while (elapsed >= span) begin
            elapsed -= span;
            steps++;
            advance_frame(n_frames);
            // pausing mid-tick: burn whole durations without moving
            if (halted) begin
              q        = elapsed / span;
              steps   += q;
              elapsed -= q * span;
              break;
            end
            span = duration_of(frame_at);
          end
        end
      end
      KIND_LOAD: begin
        hold_time[w.frame_index] = w.duration;
      end
      KIND_SET_FRAME: begin
        if (w.frame_index < n_frames) frame_at = w.frame_index;
      end
      default: begin
        halted = !w.run;
      end
    endcase
    r.current_frame  = FRAME_W'(frame_at);
    r.is_paused      = halted;
    r.moving_forward = moving_up;
    r.frames_stepped = (steps > 65535) ? {STEP_W{1'b1}} : STEP_W'(steps);
    return r;
  endfunction

  // Mostly short durations so ticks cover several frames; some extremes
  function automatic int pick_duration();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) return 0;
    if (pick < 20) return 65535;
    if (pick < 80) return $urandom_range(1, 64);
    return $urandom_range(65, 4096);
  endfunction

  function automatic sfs_item_t random_word();
    sfs_item_t   w;
    int unsigned pick;
    w.frame_time  = 16'($urandom);
    w.frame_index = 4'($urandom);
    w.duration    = 16'($urandom);
    w.run         = 1'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 50) w.kind = KIND_TICK;
    else if (pick < 65) w.kind = KIND_LOAD;
    else if (pick < 80) w.kind = KIND_SET_FRAME;
    else w.kind = KIND_RUN;
    pick = $urandom_range(0, 99);
    case (w.kind)
      KIND_TICK: begin
        // keep most time steps short; full range now and then
        if (pick < 80) w.frame_time = 16'($urandom_range(0, 511));
        else if (pick < 95) w.frame_time = 16'($urandom_range(0, 4095));
      end
      KIND_LOAD: begin
        w.duration = 16'(pick_duration());
      end
      KIND_SET_FRAME: begin
        if (pick < 75 && cfg_count != 0) w.frame_index = 4'($urandom_range(0, cfg_count - 1));
      end
      default: begin
        w.run = (pick < 80);
      end
    endcase
    return w;
  endfunction

  // Offer one word, hold it until taken, then record what it should produce
  task automatic send_word(input sfs_item_t w, input bit typed, input sfs_result_t want);
    sfs_result_t foreseen;
    item       <= w;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    foreseen = sequence_step(w);
    expected_frames.push_back(typed ? want : foreseen);
    words_sent++;
    if (w.kind == KIND_TICK) begin
      ticks_sent++;
      steps_total += foreseen.frames_stepped;
    end
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      item_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
    end
  endtask

  task automatic drain_words();
    item_valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_xfer(input logic [1:0] idx, input logic wr,
                          input logic [APB_DATA_W-1:0] wdata,
                          output logic [APB_DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Write all registers while idle, then read them back
  task automatic set_mode(input int cnt, input bit lp, input bit rw);
    logic [APB_DATA_W-1:0] rd;
    logic [APB_DATA_W-1:0] want [3];
    drain_words();
    want[0] = APB_DATA_W'(cnt);
    want[1] = APB_DATA_W'(lp);
    want[2] = APB_DATA_W'(rw);
    for (int i = 0; i < 3; i++) apb_xfer(reg_ids[i], 1'b1, want[i], rd);
    for (int i = 0; i < 3; i++) begin
      apb_xfer(reg_ids[i], 1'b0, '0, rd);
      if (rd !== want[i])
        note_mismatch($sformatf("register %0d read %0h, expected %0h", reg_ids[i], rd, want[i]));
    end
    cfg_count  = cnt;
    cfg_loop   = lp;
    cfg_rewind = rw;
    modes_used++;
  endtask

  // Receiver: random stall, plus one long hold-off when asked
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done    <= 1'b1;
      hold_left    <= HOLD_CYCLES;
      result_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  // Compare each accepted result word with the oldest expectation
  always @(posedge clk) begin : result_check
    sfs_result_t want;
    if (!rst && result_valid && !result_stall) begin
      results_seen++;
      if (expected_frames.size() == 0) begin
        note_mismatch($sformatf("unexpected word frame=%0d paused=%0b fwd=%0b steps=%0d",
                                result.current_frame, result.is_paused,
                                result.moving_forward, result.frames_stepped));
      end else begin
        want = expected_frames.pop_front();
        if (result.current_frame !== want.current_frame ||
            result.is_paused !== want.is_paused ||
            result.moving_forward !== want.moving_forward ||
            result.frames_stepped !== want.frames_stepped)
          note_mismatch($sformatf(
            "word %0d: expected frame=%0d paused=%0b fwd=%0b steps=%0d, got %0d/%0b/%0b/%0d",
            results_seen, want.current_frame, want.is_paused, want.moving_forward,
            want.frames_stepped, result.current_frame, result.is_paused,
            result.moving_forward, result.frames_stepped));
      end
    end
  end

  initial begin : stimulus
    // Directed plan: reset state, short and zero durations, saturation,
    // out-of-range jumps, clamping after a count change, ping-pong
    dir_rows.push_back(word_row(mk_word(KIND_TICK, 16'hFFFF, 0, 0, 0), 1, '{4'd0, 1, 1, 16'd0}));
    dir_rows.push_back(word_row(mk_word(KIND_RUN, 0, 0, 0, 1), 1, '{4'd0, 0, 1, 16'd0}));
    dir_rows.push_back(word_row(mk_word(KIND_TICK, 16'hFFFF, 0, 0, 0), 1, '{4'd0, 0, 1, 16'd0}));
    dir_rows.push_back(word_row(mk_word(KIND_SET_FRAME, 0, 15, 0, 0), 1, '{4'd0, 0, 1, 16'd0}));
    dir_rows.push_back(word_row(mk_word(KIND_LOAD, 0, 0, 0, 0), 1, '{4'd0, 0, 1, 16'd0}));
    dir_rows.push_back(word_row(mk_word(KIND_LOAD, 0, 1, 16'hFFFF, 0), 0, '0));
    dir_rows.push_back(word_row(mk_word(KIND_LOAD, 0, 2, 3, 0), 0, '0));
    dir_rows.push_back(word_row(mk_word(KIND_LOAD, 0, 3, 1, 0), 0, '0));
    dir_rows.push_back(mode_row(4, 0, 0));
    dir_rows.push_back(word_row(mk_word(KIND_SET_FRAME, 0, 3, 0, 0), 1, '{4'd3, 0, 1, 16'd0}));
    dir_rows.push_back(word_row(mk_word(KIND_TICK, 16'hFFFF, 0, 0, 0), 1,
                                '{4'd3, 1, 1, 16'hFFFF}));
    dir_rows.push_back(word_row(mk_word(KIND_SET_FRAME, 0, 9, 0, 0), 1, '{4'd3, 1, 1, 16'd0}));
    dir_rows.push_back(word_row(mk_word(KIND_RUN, 0, 0, 0, 1), 1, '{4'd3, 0, 1, 16'd0}));
    dir_rows.push_back(word_row(mk_word(KIND_SET_FRAME, 0, 0, 0, 0), 0, '0));
    dir_rows.push_back(word_row(mk_word(KIND_TICK, 3, 0, 0, 0), 0, '0));
    dir_rows.push_back(word_row(mk_word(KIND_TICK, 16'hFFFF, 0, 0, 0), 0, '0));
    dir_rows.push_back(word_row(mk_word(KIND_TICK, 0, 0, 0, 0), 0, '0));
    dir_rows.push_back(word_row(mk_word(KIND_RUN, 0, 0, 0, 0), 0, '0));
    dir_rows.push_back(word_row(mk_word(KIND_TICK, 5, 0, 0, 0), 0, '0));
    dir_rows.push_back(mode_row(2, 1, 1));
    dir_rows.push_back(word_row(mk_word(KIND_RUN, 0, 0, 0, 1), 0, '0));
    dir_rows.push_back(word_row(mk_word(KIND_TICK, 7, 0, 0, 0), 0, '0));
    dir_rows.push_back(word_row(mk_word(KIND_TICK, 16'hFFFF, 0, 0, 0), 0, '0));
    dir_rows.push_back(word_row(mk_word(KIND_SET_FRAME, 0, 1, 0, 0), 0, '0));
    dir_rows.push_back(word_row(mk_word(KIND_TICK, 2, 0, 0, 0), 0, '0));
    dir_rows.push_back(mode_row(3, 0, 1));
    dir_rows.push_back(word_row(mk_word(KIND_RUN, 0, 0, 0, 1), 0, '0));
    dir_rows.push_back(word_row(mk_word(KIND_TICK, 16'hFFFF, 0, 0, 0), 0, '0));

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_mode) set_mode(dir_rows[i].cnt, dir_rows[i].lp, dir_rows[i].rw);
      else send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].want);
    end

    // Random phases over several register settings and idle patterns
    for (int p = 0; p < PHASES; p++) begin
      set_mode(plan_count[p], plan_loop[p], plan_rewind[p]);
      if (p < 4) begin
        tx_idle_pct = 26;
        rx_idle_pct = 71;
      end else if (p < PRESSURE_PHASE) begin
        tx_idle_pct = 71;
        rx_idle_pct = 26;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      // fill every duration before any tick can reach a frame
      if (p == 0) begin
        for (int f = 0; f < MAX_FRAMES; f++)
          send_word(mk_word(KIND_LOAD, $urandom, f, pick_duration(), 1'($urandom)), 0, '0);
      end
      if (p == PRESSURE_PHASE) hold_req <= 1'b1;
      repeat (WORDS_PER_PHASE) send_word(random_word(), 0, '0);
    end

    drain_words();
    repeat (20) @(posedge clk);
    $display("Covered %0d words (%0d ticks, %0d frame steps) across %0d register settings.",
             words_sent, ticks_sent, steps_total, modes_used);
    $display("Checked %0d result words, %0d mismatches.", results_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### files.f
rtl/sfs_pkg.sv
rtl/sfs_ctrl.sv
rtl/sfs_dp.sv
rtl/sprite_frame_sequencer_unit.sv
test/tb.sv
